[hw/rtl/mstt_pkg.sv]
// Package for the multi-slot software timer table.
// Field widths, command/result codes, table entry and control/status structs.
// No dependencies.
package mstt_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned CD_W   = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned MODE_W = 2;

  // A scan reports at most this many fire events.
  localparam int unsigned MAX_FIRES = 8;
  localparam int unsigned FCNT_W    = $clog2(MAX_FIRES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SCAN       = 3'd1,
    CMD_REGISTER   = 3'd2,
    CMD_SET_REPEAT = 3'd3,
    CMD_SET_PERIOD = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_REMOVE_ALL = 3'd6,
    CMD_QUERY      = 3'd7
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRE   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_ANSWER = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 2'd0,
    MODE_PERIODIC = 2'd1,
    MODE_COUNTED  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0]  period;
    logic [CD_W-1:0]   countdown;
    logic [VAL_W-1:0]  repeats;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;   // take the input transaction
    logic start;   // first cycle of a command
    logic rd_en;   // read the table entry at the walk index
    logic ev;      // evaluate the entry read last cycle
    logic wr_fin;  // finish a register command
    logic emit;    // deliver the final result
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic skip;       // no table walk needed
    logic single;     // one-slot command
    logic walk_reg;   // register command, needs the finish step
    logic ev_hold;    // evaluation blocked by a full output
    logic scan_full;  // this evaluation produces the last allowed fire
    logic out_free;   // output register can take a result
  } stat_t;

endpackage

[hw/rtl/mstt_cmd_if.sv]
// Command channel of the timer table: valid/ready plus one input item.
// Depends on mstt_pkg for field widths.
interface mstt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [mstt_pkg::CMD_W-1:0]   command;
  logic [mstt_pkg::KEY_W-1:0]   key;
  logic [mstt_pkg::SLOT_W-1:0]  slot;
  logic [mstt_pkg::VAL_W-1:0]   value;

  modport source (output valid, command, key, slot, value, input ready);
  modport sink   (input valid, command, key, slot, value, output ready);
endinterface

[hw/rtl/mstt_res_if.sv]
// Result channel of the timer table: valid/ready plus one result item.
// Depends on mstt_pkg for field widths.
interface mstt_res_if;
  logic                         valid;
  logic                         ready;
  logic [mstt_pkg::KIND_W-1:0]  kind;
  logic [mstt_pkg::STAT_W-1:0]  status;
  logic [mstt_pkg::SLOT_W-1:0]  slot_out;
  logic [mstt_pkg::KEY_W-1:0]   key_out;
  logic                         expired;
  logic                         last;

  modport source (output valid, kind, status, slot_out, key_out, expired, last, input ready);
  modport sink   (input valid, kind, status, slot_out, key_out, expired, last, output ready);
endinterface

[hw/rtl/mstt_ctrl.sv]
// Sequencer of the timer table: walks the table one entry per read/evaluate pair.
// Depends on mstt_pkg (ctrl_t, stat_t).
module mstt_ctrl #(
  parameter int unsigned SLOTS = mstt_pkg::SLOTS_DEF,
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mstt_pkg::stat_t stat_i,
  input  logic [IW-1:0]   sidx_i,
  output mstt_pkg::ctrl_t ctrl_o,
  output logic [IW-1:0]   idx_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    ctrl_o     = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_START;
        end
      end
      S_START: begin
        ctrl_o.start = 1'b1;
        if (stat_i.skip) begin
          state_d = S_DONE;
        end else begin
          idx_d   = stat_i.single ? sidx_i : '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = S_EV;
      end
      S_EV: begin
        ctrl_o.ev = 1'b1;
        // hold until the output can take the buffered fire event
        if (!stat_i.ev_hold) begin
          if (stat_i.single || stat_i.scan_full || idx_q == IW'(SLOTS - 1)) begin
            state_d = stat_i.walk_reg ? S_WR : S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_WR: begin
        ctrl_o.wr_fin = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        ctrl_o.emit = 1'b1;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

[hw/rtl/mstt_dpath.sv]
// Datapath of the timer table: slot memory, valid bits, pending result and output register.
// Depends on mstt_pkg (entry_t, codes, ctrl_t, stat_t).
module mstt_dpath #(
  parameter int unsigned SLOTS = mstt_pkg::SLOTS_DEF,
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mstt_pkg::ctrl_t               ctrl_i,
  input  logic [IW-1:0]                 idx_i,
  output mstt_pkg::stat_t               stat_o,
  output logic [IW-1:0]                 sidx_o,
  input  logic [mstt_pkg::CMD_W-1:0]    command_i,
  input  logic [mstt_pkg::KEY_W-1:0]    key_i,
  input  logic [mstt_pkg::SLOT_W-1:0]   slot_i,
  input  logic [mstt_pkg::VAL_W-1:0]    value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mstt_pkg::KIND_W-1:0]   kind_o,
  output logic [mstt_pkg::STAT_W-1:0]   status_o,
  output logic [mstt_pkg::SLOT_W-1:0]   slot_out_o,
  output logic [mstt_pkg::KEY_W-1:0]    key_out_o,
  output logic                          expired_o,
  output logic                          last_o
);

  // latched command
  mstt_pkg::cmd_e                 cmd_q;
  logic [mstt_pkg::KEY_W-1:0]     key_q;
  logic [mstt_pkg::SLOT_W-1:0]    slot_q;
  logic [mstt_pkg::VAL_W-1:0]     value_q;

  // table storage
  mstt_pkg::entry_t               mem_q [SLOTS];
  mstt_pkg::entry_t               rd_q;
  logic                           rd_vld_q;
  logic [SLOTS-1:0]               vld_q;

  // pending result and search state
  mstt_pkg::kind_e                pend_kind_q;
  mstt_pkg::status_e              pend_status_q;
  logic [mstt_pkg::SLOT_W-1:0]    pend_slot_q;
  logic [mstt_pkg::KEY_W-1:0]     pend_key_q;
  logic                           pend_exp_q;
  logic                           pend_fire_q;
  logic                           found_q;
  logic                           free_found_q;
  logic [IW-1:0]                  free_idx_q;
  logic [mstt_pkg::FCNT_W-1:0]    fcnt_q;

  // output register
  logic                           out_valid_q;
  mstt_pkg::kind_e                out_kind_q;
  mstt_pkg::status_e              out_status_q;
  logic [mstt_pkg::SLOT_W-1:0]    out_slot_q;
  logic [mstt_pkg::KEY_W-1:0]     out_key_q;
  logic                           out_exp_q;
  logic                           out_last_q;

  mstt_pkg::entry_t               eff;
  mstt_pkg::entry_t               ev_wd;
  mstt_pkg::entry_t               mem_wd;
  logic [IW-1:0]                  mem_wa;
  logic                           mem_we;
  logic                           occupied;
  logic                           due;
  logic                           ev_we;
  logic                           ev_vclr;
  logic                           fire;
  logic                           match;
  logic                           entry_exp;
  logic                           slot_cmd;
  logic                           in_range;
  logic                           out_free;
  logic                           ev_act;
  logic                           push;
  logic                           final_load;
  logic                           we_wr;

  // an entry that is not valid reads as a free, all-zero slot
  assign eff      = rd_vld_q ? rd_q : '0;
  assign occupied = (eff.key != '0);
  assign due      = (eff.countdown == '0) || eff.countdown[mstt_pkg::CD_W-1];
  assign entry_exp = (eff.mode == mstt_pkg::MODE_PERIODIC) ? due :
                     (eff.mode == mstt_pkg::MODE_COUNTED) ? (eff.repeats != '0) : 1'b0;
  // only key searches look for a match
  assign match    = occupied && (eff.key == key_q) &&
                    ((cmd_q == mstt_pkg::CMD_REGISTER) || (cmd_q == mstt_pkg::CMD_QUERY));

  assign slot_cmd = (cmd_q == mstt_pkg::CMD_SET_REPEAT) || (cmd_q == mstt_pkg::CMD_SET_PERIOD) ||
                    (cmd_q == mstt_pkg::CMD_REMOVE);
  assign in_range = (32'(slot_q) < SLOTS);
  assign sidx_o   = IW'(slot_q);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ev_wd   = eff;
    ev_we   = 1'b0;
    ev_vclr = 1'b0;
    fire    = 1'b0;
    case (cmd_q)
      mstt_pkg::CMD_TICK: begin
        if (occupied && !eff.countdown[mstt_pkg::CD_W-1]) begin
          ev_we           = 1'b1;
          ev_wd.countdown = eff.countdown - {1'b0, value_q};
        end
      end
      mstt_pkg::CMD_SCAN: begin
        if (occupied && due) begin
          if (eff.mode == mstt_pkg::MODE_PERIODIC) begin
            fire            = 1'b1;
            ev_we           = 1'b1;
            ev_wd.countdown = {1'b0, eff.period};
          end else if (eff.mode == mstt_pkg::MODE_COUNTED && eff.repeats != '0) begin
            fire            = 1'b1;
            ev_we           = 1'b1;
            ev_wd.repeats   = eff.repeats - mstt_pkg::VAL_W'(1);
            ev_wd.countdown = {1'b0, eff.period};
            // last repeat frees the slot
            ev_vclr         = (eff.repeats == mstt_pkg::VAL_W'(1));
          end
        end
      end
      mstt_pkg::CMD_SET_REPEAT: begin
        if (occupied) begin
          ev_we         = 1'b1;
          ev_wd.repeats = value_q;
          ev_wd.mode    = mstt_pkg::MODE_COUNTED;
        end
      end
      mstt_pkg::CMD_SET_PERIOD: begin
        if (occupied) begin
          ev_we           = 1'b1;
          ev_wd.period    = value_q;
          ev_wd.countdown = {1'b0, value_q};
        end
      end
      mstt_pkg::CMD_REMOVE: begin
        ev_vclr = occupied;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.skip      = (cmd_q == mstt_pkg::CMD_REMOVE_ALL) ||
                            (((cmd_q == mstt_pkg::CMD_REGISTER) || (cmd_q == mstt_pkg::CMD_QUERY))
                             && key_q == '0) ||
                            (slot_cmd && !in_range);
  assign stat_o.single    = slot_cmd;
  assign stat_o.walk_reg  = (cmd_q == mstt_pkg::CMD_REGISTER);
  assign stat_o.ev_hold   = fire && pend_fire_q && !out_free;
  assign stat_o.scan_full = fire && (fcnt_q == mstt_pkg::FCNT_W'(mstt_pkg::MAX_FIRES - 1));
  assign stat_o.out_free  = out_free;

  assign ev_act     = ctrl_i.ev && !stat_o.ev_hold;
  assign push       = ev_act && fire && pend_fire_q;
  assign final_load = ctrl_i.emit && out_free;
  assign we_wr      = ctrl_i.wr_fin && !found_q && free_found_q;

  always_comb begin
    mem_we = (ev_act && ev_we) || we_wr;
    mem_wa = idx_i;
    mem_wd = ev_wd;
    if (ctrl_i.wr_fin) begin
      mem_wa           = free_idx_q;
      mem_wd.key       = key_q;
      mem_wd.mode      = mstt_pkg::MODE_PERIODIC;
      mem_wd.period    = value_q;
      mem_wd.countdown = {1'b0, value_q};
      mem_wd.repeats   = '0;
    end
  end

  // slot memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[idx_i];
      end
      if (ctrl_i.start && cmd_q == mstt_pkg::CMD_REMOVE_ALL) begin
        vld_q <= '0;
      end else begin
        if (ev_act && ev_vclr) begin
          vld_q[idx_i] <= 1'b0;
        end
        if (we_wr) begin
          vld_q[free_idx_q] <= 1'b1;
        end
      end
    end
  end

  // control flags of the current command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_fire_q  <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      fcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl_i.latch) begin
        pend_fire_q  <= 1'b0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        fcnt_q       <= '0;
      end else if (ev_act) begin
        if (fire) begin
          pend_fire_q <= 1'b1;
          fcnt_q      <= fcnt_q + 1'b1;
        end
        if (match) begin
          found_q <= 1'b1;
        end
        if (!occupied) begin
          free_found_q <= 1'b1;
        end
      end
      if (push || final_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command fields, pending result and output payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q       <= mstt_pkg::cmd_e'(command_i);
      key_q       <= key_i;
      slot_q      <= slot_i;
      value_q     <= value_i;
      pend_kind_q <= (mstt_pkg::cmd_e'(command_i) == mstt_pkg::CMD_QUERY) ?
                     mstt_pkg::KIND_ANSWER : mstt_pkg::KIND_ACK;
      case (mstt_pkg::cmd_e'(command_i)) inside
        mstt_pkg::CMD_TICK, mstt_pkg::CMD_SCAN, mstt_pkg::CMD_REMOVE_ALL:
          pend_status_q <= mstt_pkg::ST_OK;
        default:
          pend_status_q <= mstt_pkg::ST_NOTFOUND;
      endcase
      pend_slot_q <= '0;
      pend_key_q  <= '0;
      pend_exp_q  <= 1'b0;
    end else if (ev_act) begin
      if (fire) begin
        pend_kind_q   <= mstt_pkg::KIND_FIRE;
        pend_status_q <= mstt_pkg::ST_OK;
        pend_slot_q   <= mstt_pkg::SLOT_W'(idx_i);
        pend_key_q    <= eff.key;
        pend_exp_q    <= 1'b0;
      end
      if (match && !found_q) begin
        pend_status_q <= (cmd_q == mstt_pkg::CMD_REGISTER) ? mstt_pkg::ST_DUP : mstt_pkg::ST_OK;
        pend_slot_q   <= mstt_pkg::SLOT_W'(idx_i);
        pend_key_q    <= key_q;
        pend_exp_q    <= (cmd_q == mstt_pkg::CMD_QUERY) ? entry_exp : 1'b0;
      end
      if (!occupied && !free_found_q) begin
        free_idx_q <= idx_i;
      end
      if (slot_cmd && occupied) begin
        pend_status_q <= mstt_pkg::ST_OK;
        pend_slot_q   <= slot_q;
        pend_key_q    <= eff.key;
      end
    end else if (ctrl_i.wr_fin && !found_q) begin
      if (free_found_q) begin
        pend_status_q <= mstt_pkg::ST_OK;
        pend_slot_q   <= mstt_pkg::SLOT_W'(free_idx_q);
        pend_key_q    <= key_q;
      end else begin
        pend_status_q <= mstt_pkg::ST_FULL;
      end
    end
    if (push || final_load) begin
      out_kind_q   <= pend_kind_q;
      out_status_q <= pend_status_q;
      out_slot_q   <= pend_slot_q;
      out_key_q    <= pend_key_q;
      out_exp_q    <= pend_exp_q;
      out_last_q   <= final_load;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign status_o    = out_status_q;
  assign slot_out_o  = out_slot_q;
  assign key_out_o   = out_key_q;
  assign expired_o   = out_exp_q;
  assign last_o      = out_last_q;

endmodule

[hw/rtl/multi_slot_software_timer_table_core.sv]
// Top level of the multi-slot software timer table.
// Depends on mstt_pkg, mstt_cmd_if, mstt_res_if, mstt_ctrl and mstt_dpath.
//
//   channel | direction | payload                                       | handshake
//   cmd_i   | in        | command, key, slot, value                     | valid/ready
//   res_o   | out       | kind, status, slot_out, key_out, expired, last | valid/ready
//
// One command at a time. Table walks (tick, scan, register, query) read one entry at a
// time from the slot memory, a read state then an evaluate state per entry; register
// adds a finish step, slot commands read only their slot and remove all skips the walk.
// Reset clears every valid bit at once; no clearing pass is needed.
// A stalled output holds scan fire events and the final result; the walk waits on it.
// The next command is accepted while the final result of the last one waits.
module multi_slot_software_timer_table_core #(
  parameter int unsigned SLOTS = mstt_pkg::SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mstt_cmd_if.sink   cmd_i,
  mstt_res_if.source res_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  mstt_pkg::ctrl_t ctrl;
  mstt_pkg::stat_t stat;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   sidx;
  logic            in_ready;

  assign cmd_i.ready = in_ready;

  mstt_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(cmd_i.valid),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .sidx_i    (sidx),
    .ctrl_o    (ctrl),
    .idx_o     (idx)
  );

  mstt_dpath #(
    .SLOTS(SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .idx_i      (idx),
    .stat_o     (stat),
    .sidx_o     (sidx),
    .command_i  (cmd_i.command),
    .key_i      (cmd_i.key),
    .slot_i     (cmd_i.slot),
    .value_i    (cmd_i.value),
    .out_ready_i(res_o.ready),
    .out_valid_o(res_o.valid),
    .kind_o     (res_o.kind),
    .status_o   (res_o.status),
    .slot_out_o (res_o.slot_out),
    .key_out_o  (res_o.key_out),
    .expired_o  (res_o.expired),
    .last_o     (res_o.last)
  );

endmodule

[hw/rtl/mstt_chk.sv]
// Port-level checker for the timer table, bound to the top level.
// Depends on mstt_pkg for result codes.
module mstt_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mstt_pkg::KIND_W-1:0]  kind_i,
  input logic [mstt_pkg::STAT_W-1:0]  status_i,
  input logic [mstt_pkg::SLOT_W-1:0]  slot_i,
  input logic [mstt_pkg::KEY_W-1:0]   key_i,
  input logic                         expired_i,
  input logic                         last_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(status_i) &&
    $stable(slot_i) && $stable(key_i) && $stable(expired_i) && $stable(last_i))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after a command transaction");

  // no new command while an intermediate result waits
  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("ready while a non-final result waits");

  a_expired_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && expired_i |-> kind_i == mstt_pkg::KIND_ANSWER && status_i == mstt_pkg::ST_OK)
    else $error("expired set on a result that is not a found query");

  a_fire_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == mstt_pkg::KIND_FIRE |-> status_i == mstt_pkg::ST_OK && key_i != '0)
    else $error("fire event without a key");

endmodule

bind multi_slot_software_timer_table_core mstt_chk u_mstt_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (cmd_i.valid),
  .in_ready_i (cmd_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .kind_i     (res_o.kind),
  .status_i   (res_o.status),
  .slot_i     (res_o.slot_out),
  .key_i      (res_o.key_out),
  .expired_i  (res_o.expired),
  .last_i     (res_o.last)
);

[verif/multi_slot_software_timer_table_core_test.sv]
// Testbench for multi_slot_software_timer_table_core: drives commands, predicts every
// result from a local copy of the timer table and checks each result transaction.
// Depends on mstt_pkg, mstt_cmd_if, mstt_res_if and the core.
`timescale 1ns / 100ps

module multi_slot_software_timer_table_core_test;
  import mstt_pkg::*;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned TAIL_WAIT  = 2 * SLOTS + 12;
  localparam int unsigned RAND_ITEMS = 480;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    cmd_e              command;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;
  } cmd_item_t;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic              expired;
    logic              last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  mstt_cmd_if cmd_if ();
  mstt_res_if res_if ();

  multi_slot_software_timer_table_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // Local copy of the timer table.
  logic [KEY_W-1:0] tbl_key[SLOTS];
  mode_e            tbl_mode[SLOTS];
  logic [VAL_W-1:0] tbl_period[SLOTS];
  logic [CD_W-1:0]  tbl_cd[SLOTS];
  logic [VAL_W-1:0] tbl_rep[SLOTS];

  cmd_item_t cmd_backlog[$];
  result_t   due_results[$];
  cmd_item_t cur_cmd;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned stall_cycles;

  // Idling stops in this stretch of the run.
  wire quiet = (n_accepted >= 300) && (n_accepted < 400);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report(string msg);
    n_errors++;
    if (n_errors <= 20) $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic void clear_entry(int i);
    tbl_key[i]    = '0;
    tbl_mode[i]   = MODE_NONE;
    tbl_period[i] = '0;
    tbl_cd[i]     = '0;
    tbl_rep[i]    = '0;
  endfunction

  function automatic int find_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void push_result(kind_e kind, status_e status, int slot,
                                      logic [KEY_W-1:0] key, logic expired, logic last);
    result_t r;
    r.kind    = kind;
    r.status  = status;
    r.slot    = SLOT_W'(slot);
    r.key     = key;
    r.expired = expired;
    r.last    = last;
    due_results.push_back(r);
  endfunction

  function automatic bit not_positive(logic [CD_W-1:0] c);
    return (c == '0) || c[CD_W-1];
  endfunction

  // Apply one accepted command to the local table and queue its results.
  function automatic void apply_timer_cmd(cmd_item_t it);
    int               fires;
    int               f;
    logic [KEY_W-1:0] k;
    logic             due;
    fires = 0;
    case (it.command)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_key[i] != '0 && !tbl_cd[i][CD_W-1]) tbl_cd[i] = tbl_cd[i] - {1'b0, it.value};
        end
        push_result(KIND_ACK, ST_OK, 0, '0, 1'b0, 1'b1);
      end
      CMD_SCAN: begin
        for (int i = 0; i < SLOTS && fires < MAX_FIRES; i++) begin
          k = tbl_key[i];
          if (k == '0 || !not_positive(tbl_cd[i])) continue;
          if (tbl_mode[i] == MODE_PERIODIC) begin
            tbl_cd[i] = {1'b0, tbl_period[i]};
          end else if (tbl_mode[i] == MODE_COUNTED) begin
            // a counted slot with no repeats left stays put and never fires
            if (tbl_rep[i] == '0) continue;
            tbl_rep[i] = tbl_rep[i] - 1'b1;
            tbl_cd[i]  = {1'b0, tbl_period[i]};
            if (tbl_rep[i] == '0) clear_entry(i);
          end else begin
            continue;
          end
          push_result(KIND_FIRE, ST_OK, i, k, 1'b0, 1'b0);
          fires++;
        end
        if (fires == 0) push_result(KIND_ACK, ST_OK, 0, '0, 1'b0, 1'b1);
        else due_results[due_results.size()-1].last = 1'b1;
      end
      CMD_REGISTER: begin
        if (it.key == '0) begin
          push_result(KIND_ACK, ST_NOTFOUND, 0, '0, 1'b0, 1'b1);
        end else begin
          f = find_key(it.key);
          if (f >= 0) begin
            push_result(KIND_ACK, ST_DUP, f, it.key, 1'b0, 1'b1);
          end else begin
            f = find_key('0);
            if (f < 0) begin
              push_result(KIND_ACK, ST_FULL, 0, '0, 1'b0, 1'b1);
            end else begin
              tbl_key[f]    = it.key;
              tbl_mode[f]   = MODE_PERIODIC;
              tbl_period[f] = it.value;
              tbl_cd[f]     = {1'b0, it.value};
              push_result(KIND_ACK, ST_OK, f, it.key, 1'b0, 1'b1);
            end
          end
        end
      end
      CMD_SET_REPEAT, CMD_SET_PERIOD, CMD_REMOVE: begin
        if (it.slot >= SLOTS || tbl_key[it.slot] == '0) begin
          push_result(KIND_ACK, ST_NOTFOUND, 0, '0, 1'b0, 1'b1);
        end else begin
          k = tbl_key[it.slot];
          if (it.command == CMD_SET_REPEAT) begin
            tbl_rep[it.slot]  = it.value;
            tbl_mode[it.slot] = MODE_COUNTED;
          end else if (it.command == CMD_SET_PERIOD) begin
            tbl_period[it.slot] = it.value;
            tbl_cd[it.slot]     = {1'b0, it.value};
          end else begin
            clear_entry(it.slot);
          end
          push_result(KIND_ACK, ST_OK, it.slot, k, 1'b0, 1'b1);
        end
      end
      CMD_REMOVE_ALL: begin
        for (int i = 0; i < SLOTS; i++) clear_entry(i);
        push_result(KIND_ACK, ST_OK, 0, '0, 1'b0, 1'b1);
      end
      default: begin
        f = (it.key == '0) ? -1 : find_key(it.key);
        if (f < 0) begin
          push_result(KIND_ANSWER, ST_NOTFOUND, 0, '0, 1'b0, 1'b1);
        end else begin
          due = 1'b0;
          if (tbl_mode[f] == MODE_PERIODIC) due = not_positive(tbl_cd[f]);
          else if (tbl_mode[f] == MODE_COUNTED) due = (tbl_rep[f] != '0);
          push_result(KIND_ANSWER, ST_OK, f, it.key, due, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic add_cmd(cmd_e c, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] slot,
                         logic [VAL_W-1:0] value);
    cmd_item_t it;
    it.command = c;
    it.key     = key;
    it.slot    = slot;
    it.value   = value;
    cmd_backlog.push_back(it);
    n_queued++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return KEY_W'($urandom_range(1, 12));
    if (r < 95) return KEY_W'($urandom_range(0, 65535));
    return '0;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(int unsigned small_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return VAL_W'($urandom_range(0, small_max));
    if (r < 92) return VAL_W'($urandom_range(0, 1000));
    return VAL_W'($urandom);
  endfunction

  // Driver: present items from the backlog, hold each until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_timer_cmd(cur_cmd);
        n_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_backlog.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
          cur_cmd = cmd_backlog.pop_front();
          cmd_if.valid   <= 1'b1;
          cmd_if.command <= cur_cmd.command;
          cmd_if.key     <= cur_cmd.key;
          cmd_if.slot    <= cur_cmd.slot;
          cmd_if.value   <= cur_cmd.value;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          report($sformatf("unexpected result kind %0d status %0d slot %0d key %h",
                           res_if.kind, res_if.status, res_if.slot_out, res_if.key_out));
        end else begin
          want = due_results.pop_front();
          if (res_if.kind !== want.kind || res_if.status !== want.status ||
              res_if.slot_out !== want.slot || res_if.key_out !== want.key ||
              res_if.expired !== want.expired || res_if.last !== want.last) begin
            report($sformatf("got %0d/%0d/%0d/%h/%b/%b want %0d/%0d/%0d/%h/%b/%b",
                             res_if.kind, res_if.status, res_if.slot_out, res_if.key_out,
                             res_if.expired, res_if.last, want.kind, want.status,
                             want.slot, want.key, want.expired, want.last));
          end
        end
      end
      // One long hold-off lets the core fill up and stall the command side.
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && n_accepted >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    cmd_e c;
    int unsigned r;
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_TICK;
    cmd_if.key     = '0;
    cmd_if.slot    = '0;
    cmd_if.value   = '0;
    res_if.ready   = 1'b0;
    n_queued       = 0;
    n_accepted     = 0;
    n_errors       = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    stall_cycles   = 0;
    for (int i = 0; i < SLOTS; i++) clear_entry(i);

    // Directed: rejects on an empty table, duplicate behind a hole, full table,
    // counted slots, tick over negative countdowns and a scan that fires everything.
    add_cmd(CMD_QUERY, 16'h0000, 3'd0, '0);
    add_cmd(CMD_REGISTER, 16'h0000, 3'd0, 31'd5);
    add_cmd(CMD_SET_PERIOD, 16'h0000, 3'd7, 31'd5);
    add_cmd(CMD_SCAN, 16'h0000, 3'd0, '0);
    add_cmd(CMD_TICK, 16'h0000, 3'd0, '0);
    add_cmd(CMD_REGISTER, 16'hFFFF, 3'd7, '0);
    add_cmd(CMD_REGISTER, 16'h0001, 3'd0, VAL_MAX);
    add_cmd(CMD_REMOVE, 16'h0000, 3'd0, '0);
    add_cmd(CMD_REGISTER, 16'h0001, 3'd0, 31'd5);
    for (int k = 2; k <= 8; k++) add_cmd(CMD_REGISTER, KEY_W'(k), 3'd0, 31'd3);
    add_cmd(CMD_REGISTER, 16'h1234, 3'd0, 31'd3);
    add_cmd(CMD_SET_REPEAT, 16'h0000, 3'd2, 31'd1);
    add_cmd(CMD_SET_REPEAT, 16'h0000, 3'd4, VAL_MAX);
    add_cmd(CMD_QUERY, 16'h0001, 3'd0, '0);
    add_cmd(CMD_TICK, 16'h0000, 3'd0, VAL_MAX);
    add_cmd(CMD_SCAN, 16'hFFFF, 3'd7, VAL_MAX);
    add_cmd(CMD_SET_REPEAT, 16'h0000, 3'd3, '0);
    add_cmd(CMD_TICK, 16'h0000, 3'd0, VAL_MAX);
    add_cmd(CMD_TICK, 16'h0000, 3'd0, 31'd7);
    add_cmd(CMD_SCAN, 16'h0000, 3'd0, '0);
    add_cmd(CMD_QUERY, 16'h0004, 3'd0, '0);
    add_cmd(CMD_REMOVE_ALL, 16'h0000, 3'd0, '0);

    // Random: mostly table traffic over a small key pool, some noise.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 18) c = CMD_TICK;
      else if (r < 38) c = CMD_SCAN;
      else if (r < 55) c = CMD_REGISTER;
      else if (r < 63) c = CMD_SET_REPEAT;
      else if (r < 70) c = CMD_SET_PERIOD;
      else if (r < 78) c = CMD_REMOVE;
      else if (r < 80) c = CMD_REMOVE_ALL;
      else if (r < 92) c = CMD_QUERY;
      else c = cmd_e'($urandom_range(0, 7));
      if (r >= 92) begin
        add_cmd(c, KEY_W'($urandom), SLOT_W'($urandom), VAL_W'($urandom));
      end else begin
        add_cmd(c, pick_key(), SLOT_W'($urandom_range(0, 7)),
                pick_value((c == CMD_SET_REPEAT) ? 4 : 20));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_queued || due_results.size() > 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (n_errors == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
